// ===== hdl/hough_line_accumulator_defines.svh =====
`ifndef HOUGH_LINE_ACCUMULATOR_DEFINES_SVH
`define HOUGH_LINE_ACCUMULATOR_DEFINES_SVH

// Overlapping implication, sampled on the rising clock and held off during reset.
`define HLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication that checks the consequent in the next clock cycle.
`define HLA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hla_pkg.sv =====
`timescale 1ns / 1ps
package hla_pkg;

  localparam int DEF_ANGLE_STEPS   = 256;
  localparam int DEF_DISTANCE_BINS = 256;
  localparam int DEF_COUNT_BITS    = 16;

  // Width of the rho bin taken from the scaled distance.
  localparam int BIN_W  = 14;
  // Width of the Q1.14 cosine and sine values.
  localparam int TRIG_W = 16;

  localparam logic [63:0] PI_Q30  = 64'hC90F_DAA2;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  localparam logic [15:0]        THRESHOLD_RST = 16'd10;
  localparam logic signed [15:0] ORIGIN_RST    = -16'sd20480;
  localparam logic [15:0]        SCALE_RST     = 16'd3277;

  typedef enum logic [1:0] {
    OP_VOTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } hla_op_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ORIGIN    = 2'd1,
    REG_SCALE     = 2'd2
  } hla_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_READ_ADDR,
    ST_READ_DATA
  } hla_state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [7:0]        angle_index;
    logic [7:0]        distance_index;
  } hla_cmd_t;

  typedef struct packed {
    logic [15:0] cell_count;
    logic        is_peak;
  } hla_result_t;

  typedef struct packed {
    logic [15:0]        vote_threshold;
    logic signed [15:0] rho_origin;
    logic [15:0]        rho_bin_scale;
  } hla_cfg_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } hla_rho_stat_t;

endpackage

// ===== hdl/hla_trig_rom.sv =====
`timescale 1ns / 1ps
module hla_trig_rom import hla_pkg::*; #(
  parameter int  ANGLE_STEPS = DEF_ANGLE_STEPS,
  localparam int AW          = $clog2(ANGLE_STEPS)
) (
  input  logic                     clk_i,
  input  logic [AW-1:0]            angle_i,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic signed [TRIG_W-1:0] cos_tab [ANGLE_STEPS];
  logic signed [TRIG_W-1:0] sin_tab [ANGLE_STEPS];

  // Each entry is a truncating Horner series in Q2.30 on the angle folded into the
  // first quadrant, rounded half up to Q1.14. All of it is worked out at elaboration.
  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_entry
    localparam bit          UPPER = (2 * g) > ANGLE_STEPS;
    localparam logic [63:0] M     = UPPER ? 64'(ANGLE_STEPS - g) : 64'(g);
    localparam logic [63:0] X     = (PI_Q30 * M) / 64'(ANGLE_STEPS);
    localparam logic [63:0] X2    = (X * X) >> 30;

    localparam logic [63:0] S1 = ONE_Q30 - ((X2 * ONE_Q30) >> 30) / 64'd110;
    localparam logic [63:0] S2 = ONE_Q30 - ((X2 * S1) >> 30) / 64'd72;
    localparam logic [63:0] S3 = ONE_Q30 - ((X2 * S2) >> 30) / 64'd42;
    localparam logic [63:0] S4 = ONE_Q30 - ((X2 * S3) >> 30) / 64'd20;
    localparam logic [63:0] S5 = ONE_Q30 - ((X2 * S4) >> 30) / 64'd6;
    localparam logic [63:0] SVAL = (X * S5) >> 30;
    localparam logic [63:0] SRND = (SVAL + 64'd32768) >> 16;
    localparam logic [63:0] SQ14 = (SRND > 64'd16384) ? 64'd16384 : SRND;

    localparam logic [63:0] C1 = ONE_Q30 - ((X2 * ONE_Q30) >> 30) / 64'd132;
    localparam logic [63:0] C2 = ONE_Q30 - ((X2 * C1) >> 30) / 64'd90;
    localparam logic [63:0] C3 = ONE_Q30 - ((X2 * C2) >> 30) / 64'd56;
    localparam logic [63:0] C4 = ONE_Q30 - ((X2 * C3) >> 30) / 64'd30;
    localparam logic [63:0] C5 = ONE_Q30 - ((X2 * C4) >> 30) / 64'd12;
    localparam logic [63:0] CSUB = ((X2 * C5) >> 30) / 64'd2;
    localparam logic [63:0] CVAL = (CSUB >= ONE_Q30) ? 64'd0 : (ONE_Q30 - CSUB);
    localparam logic [63:0] CRND = (CVAL + 64'd32768) >> 16;
    localparam logic [63:0] CQ14 = (CRND > 64'd16384) ? 64'd16384 : CRND;

    assign sin_tab[g] = TRIG_W'(SQ14);
    assign cos_tab[g] = UPPER ? TRIG_W'(64'd0 - CQ14) : TRIG_W'(CQ14);
  end

  always_ff @(posedge clk_i) begin
    cos_o <= cos_tab[angle_i];
    sin_o <= sin_tab[angle_i];
  end

endmodule

// ===== hdl/hla_rho_unit.sv =====
`timescale 1ns / 1ps
module hla_rho_unit import hla_pkg::*; #(
  parameter int DISTANCE_BINS = DEF_DISTANCE_BINS,
  parameter int ADDR_W        = $clog2(DEF_ANGLE_STEPS * DEF_DISTANCE_BINS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     issue_i,
  input  logic [ADDR_W-1:0]        row_i,
  input  logic signed [15:0]       point_x_i,
  input  logic signed [15:0]       point_y_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  hla_cfg_t                 cfg_i,
  output hla_rho_stat_t            stat_o,
  output logic [ADDR_W-1:0]        addr_o
);

  logic              v0_q, v1_q, v2_q, v3_q;
  logic [ADDR_W-1:0] row0_q, row1_q, row2_q, row3_q;
  logic signed [31:0] px_cos_q, py_sin_q;
  logic              neg2_q, neg3_q;
  logic [30:0]       dist2_q;
  logic [BIN_W-1:0]  bin3_q;

  logic signed [31:0] px_cos_d, py_sin_d;
  logic signed [33:0] rho, base, diff;
  logic [46:0]        scaled;

  // Stage one lines up with the registered table read.
  assign px_cos_d = point_x_i * cos_i;
  assign py_sin_d = point_y_i * sin_i;

  // Stage two: offset of rho from the origin, both in Q.25.
  assign rho  = 34'(px_cos_q) + 34'(py_sin_q);
  assign base = 34'(cfg_i.rho_origin) <<< 14;
  assign diff = rho - base;

  // Stage three: a non-negative offset stays below 2^31.
  assign scaled = 47'(dist2_q) * 47'(cfg_i.rho_bin_scale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= issue_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row0_q   <= row_i;
    row1_q   <= row0_q;
    px_cos_q <= px_cos_d;
    py_sin_q <= py_sin_d;
    row2_q   <= row1_q;
    neg2_q   <= diff[33];
    dist2_q  <= diff[30:0];
    row3_q   <= row2_q;
    neg3_q   <= neg2_q;
    bin3_q   <= scaled[46:33];
  end

  assign stat_o.busy = v0_q | v1_q | v2_q | v3_q;
  assign stat_o.hit  = v3_q && !neg3_q && (bin3_q < BIN_W'(DISTANCE_BINS));
  assign addr_o      = row3_q + ADDR_W'(bin3_q);

endmodule

// ===== hdl/hla_vote_store.sv =====
`timescale 1ns / 1ps
module hla_vote_store import hla_pkg::*; #(
  parameter int DEPTH  = DEF_ANGLE_STEPS * DEF_DISTANCE_BINS,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = DEF_COUNT_BITS
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== hdl/hough_line_accumulator.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// command   start_i, busy_o, cmd_i                  taken when start_i is high and busy_o low
// result    result_valid_o, result_o                one-cycle strobe, always taken
// config    cfg_we_i, cfg_index_i, cfg_wdata_i      written when cfg_we_i is high
//
// A vote item keeps busy_o high until its last step is written back: the rho unit takes
// one angle step per cycle and each step that hits a bin ends in one read-modify-write
// of the vote store. A read item reads the store in ST_READ_ADDR and registers its
// result in ST_READ_DATA. A clear item sweeps the store one cell a cycle over all
// ANGLE_STEPS * DISTANCE_BINS cells. After reset the same sweep runs with busy_o high;
// configuration writes are taken throughout. The result side has no stall.
module hough_line_accumulator import hla_pkg::*; #(
  parameter int ANGLE_STEPS   = DEF_ANGLE_STEPS,
  parameter int DISTANCE_BINS = DEF_DISTANCE_BINS,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  hla_cmd_t    cmd_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output hla_result_t result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int CELLS  = ANGLE_STEPS * DISTANCE_BINS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int AW     = $clog2(ANGLE_STEPS);
  localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  hla_state_e        state_q, state_d;
  logic [AW-1:0]     t_q, t_d;
  logic [ADDR_W-1:0] row_q, row_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic signed [15:0] px_q, px_d, py_q, py_d;
  logic [ADDR_W-1:0] raddr_q, raddr_d;
  logic              rin_range_q, rin_range_d;
  hla_cfg_t          cfg_q;
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;
  hla_result_t       res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic                     issue;
  logic signed [TRIG_W-1:0] cos_v, sin_v;
  hla_rho_stat_t            rho_stat;
  logic [ADDR_W-1:0]        rho_addr;

  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [COUNT_BITS-1:0] rd_data, wr_data, inc_data;
  logic [CMP_W-1:0]  cnt_ext;

  // Configuration registers. A write to an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vote_threshold <= THRESHOLD_RST;
      cfg_q.rho_origin     <= ORIGIN_RST;
      cfg_q.rho_bin_scale  <= SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_THRESHOLD: cfg_q.vote_threshold <= cfg_wdata_i;
        REG_ORIGIN:    cfg_q.rho_origin     <= cfg_wdata_i;
        REG_SCALE:     cfg_q.rho_bin_scale  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hla_trig_rom #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_trig (
    .clk_i  (clk_i),
    .angle_i(t_q),
    .cos_o  (cos_v),
    .sin_o  (sin_v)
  );

  hla_rho_unit #(
    .DISTANCE_BINS(DISTANCE_BINS),
    .ADDR_W       (ADDR_W)
  ) u_rho (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .row_i    (row_q),
    .point_x_i(px_q),
    .point_y_i(py_q),
    .cos_i    (cos_v),
    .sin_i    (sin_v),
    .cfg_i    (cfg_q),
    .stat_o   (rho_stat),
    .addr_o   (rho_addr)
  );

  hla_vote_store #(
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W),
    .DATA_W(COUNT_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // The count read for a hit comes back in the next cycle and is written back
  // incremented, saturating at the top of the count range. Successive angle steps
  // fall in different rows, so a write never meets the read issued beside it.
  assign inc_data = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : (rd_data + COUNT_BITS'(1));
  assign cnt_ext  = CMP_W'(rd_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= rho_stat.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= rho_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      t_q         <= '0;
      row_q       <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      row_q       <= row_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q        <= px_d;
    py_q        <= py_d;
    raddr_q     <= raddr_d;
    rin_range_q <= rin_range_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    row_d       = row_q;
    clr_d       = clr_q;
    px_d        = px_q;
    py_d        = py_q;
    raddr_d     = raddr_q;
    rin_range_d = rin_range_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    issue       = 1'b0;
    rd_en       = rho_stat.hit;
    rd_addr     = rho_addr;
    wr_en       = wr_pend_q;
    wr_addr     = wr_addr_q;
    wr_data     = inc_data;

    unique case (state_q)
      ST_CLEAR: begin
        // One cell a cycle is zeroed, both after reset and for a clear item.
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i.opcode)
            OP_VOTE: begin
              px_d    = cmd_i.point_x;
              py_d    = cmd_i.point_y;
              t_d     = '0;
              row_d   = '0;
              state_d = ST_VOTE;
            end
            OP_READ: begin
              raddr_d     = ADDR_W'(32'(cmd_i.angle_index) * DISTANCE_BINS
                                    + 32'(cmd_i.distance_index));
              rin_range_d = (32'(cmd_i.angle_index) < ANGLE_STEPS) &&
                            (32'(cmd_i.distance_index) < DISTANCE_BINS);
              state_d     = ST_READ_ADDR;
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_VOTE: begin
        // One angle step enters the rho unit every cycle.
        issue = 1'b1;
        t_d   = t_q + AW'(1);
        row_d = row_q + ADDR_W'(DISTANCE_BINS);
        if (t_q == AW'(ANGLE_STEPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rho_stat.busy && !wr_pend_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ_ADDR: begin
        rd_en   = 1'b1;
        rd_addr = raddr_q;
        state_d = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        // Cells outside the configured sizes read as empty and never a peak.
        res_valid_d = 1'b1;
        if (!rin_range_q) begin
          res_d.cell_count = '0;
        end else if (cnt_ext > CMP_W'(16'hFFFF)) begin
          res_d.cell_count = 16'hFFFF;
        end else begin
          res_d.cell_count = cnt_ext[15:0];
        end
        res_d.is_peak = rin_range_q && (cnt_ext >= CMP_W'(cfg_q.vote_threshold));
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== hdl/hla_checker.sv =====
`timescale 1ns / 1ps
`include "hough_line_accumulator_defines.svh"
module hla_checker import hla_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input hla_cmd_t    cmd_i,
  input logic        busy_o,
  input logic        result_valid_o
);

  // Every known command keeps the block busy in the cycle after it is taken.
  `HLA_ASSERT_NXT(a_busy_after_cmd, start_i && !busy_o && (cmd_i.opcode == OP_VOTE || cmd_i.opcode == OP_READ || cmd_i.opcode == OP_CLEAR), busy_o, "command taken without going busy")

  // A read is followed by its result strobe once it has passed the address and data states.
  `HLA_ASSERT_IMP(a_read_latency, start_i && !busy_o && cmd_i.opcode == OP_READ, ##3 result_valid_o, "read result missing at its slot")

  // The result strobe lasts a single cycle.
  `HLA_ASSERT_NXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe held longer than one cycle")

  // A result only ends a busy stretch.
  `HLA_ASSERT_IMP(a_result_after_busy, result_valid_o, $past(busy_o), "result without a preceding busy cycle")

endmodule

bind hough_line_accumulator hla_checker u_hla_checker (.*);

// ===== dv/hough_line_accumulator_checker.sv =====
`timescale 1ns / 1ps
module hough_line_accumulator_checker import hla_pkg::*; #(
  parameter int ANGLE_STEPS   = DEF_ANGLE_STEPS,
  parameter int DISTANCE_BINS = DEF_DISTANCE_BINS,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  hla_cmd_t    cmd_i,
  input  logic        busy_i,
  input  logic        result_valid_i,
  input  hla_result_t result_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          reads_pending_o
);

  localparam int CELLS        = ANGLE_STEPS * DISTANCE_BINS;
  localparam int REPORT_LIMIT = 10;

  int                    cos_q14 [ANGLE_STEPS];
  int                    sin_q14 [ANGLE_STEPS];
  logic [COUNT_BITS-1:0] vote_store [CELLS];
  logic [15:0]           threshold;
  logic signed [15:0]    origin;
  logic [15:0]           bins_per_unit;
  hla_result_t           expected_reads [$];
  int                    mismatches = 0;
  int                    pending_reads = 0;

  assign fail_count_o    = mismatches;
  assign reads_pending_o = pending_reads;

  function automatic int round_to_q14(longint unsigned v);
    longint unsigned r;
    r = (v + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return int'(r);
  endfunction

  // Sine and cosine tables in Q1.14, built from a truncated Taylor series in Q2.30
  // over the angle folded into the first quadrant.
  initial begin : trig_tables
    longint unsigned x, x2, term, m, p;
    longint          c;
    bit              upper;
    for (int t = 0; t < ANGLE_STEPS; t++) begin
      upper = 2 * t > ANGLE_STEPS;
      m = upper ? ANGLE_STEPS - t : t;
      x = (PI_Q30 * m) / ANGLE_STEPS;
      x2 = (x * x) >> 30;
      term = ONE_Q30;
      for (int k = 0; k < 5; k++)
        term = ONE_Q30 - ((x2 * term) >> 30) / ((10 - 2 * k) * (11 - 2 * k));
      sin_q14[t] = round_to_q14((x * term) >> 30);
      term = ONE_Q30;
      for (int k = 0; k < 5; k++)
        term = ONE_Q30 - ((x2 * term) >> 30) / ((11 - 2 * k) * (12 - 2 * k));
      p = ((x2 * term) >> 30) / 2;
      c = ONE_Q30 - p;
      if (c < 0) c = 0;
      cos_q14[t] = round_to_q14(c);
      if (upper) cos_q14[t] = -cos_q14[t];
    end
  end

  function automatic void cast_point(logic signed [15:0] px, logic signed [15:0] py);
    longint          base, rho, d;
    longint unsigned offset, bin;
    int              slot;
    base = longint'(origin) * 16384;
    for (int t = 0; t < ANGLE_STEPS; t++) begin
      rho = longint'(px) * cos_q14[t] + longint'(py) * sin_q14[t];
      d = rho - base;
      if (d >= 0) begin
        offset = d;
        bin = (offset * {48'd0, bins_per_unit}) >> 33;
        if (bin < DISTANCE_BINS) begin
          slot = t * DISTANCE_BINS + int'(bin);
          if (vote_store[slot] != '1) vote_store[slot] = vote_store[slot] + 1'b1;
        end
      end
    end
  endfunction

  function automatic hla_result_t lookup_cell(logic [7:0] a, logic [7:0] r);
    hla_result_t res;
    int unsigned cnt;
    cnt = 0;
    res.is_peak = 1'b0;
    if (a < ANGLE_STEPS && r < DISTANCE_BINS) begin
      cnt = vote_store[a * DISTANCE_BINS + r];
      res.is_peak = cnt >= threshold;
    end
    // Wide counters are clipped to the 16-bit result field.
    if (cnt > 65535) cnt = 65535;
    res.cell_count = cnt[15:0];
    return res;
  endfunction

  always @(posedge clk_i) begin : monitor
    hla_result_t want;
    if (!rst_ni) begin
      threshold     = THRESHOLD_RST;
      origin        = ORIGIN_RST;
      bins_per_unit = SCALE_RST;
      foreach (vote_store[i]) vote_store[i] = '0;
      expected_reads.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with no read pending: count %0d peak %0b", $realtime,
                     result_i.cell_count, result_i.is_peak);
        end else begin
          want = expected_reads.pop_front();
          if (result_i.cell_count !== want.cell_count || result_i.is_peak !== want.is_peak) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: read result: expected count %0d peak %0b, got count %0d peak %0b",
                       $realtime, want.cell_count, want.is_peak,
                       result_i.cell_count, result_i.is_peak);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_THRESHOLD: threshold = cfg_wdata_i;
          REG_ORIGIN:    origin = cfg_wdata_i;
          REG_SCALE:     bins_per_unit = cfg_wdata_i;
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        case (cmd_i.opcode)
          OP_VOTE:  cast_point(cmd_i.point_x, cmd_i.point_y);
          OP_READ:  expected_reads = {expected_reads,
                                      lookup_cell(cmd_i.angle_index, cmd_i.distance_index)};
          OP_CLEAR: foreach (vote_store[i]) vote_store[i] = '0;
          default: ;  // The spare opcode changes nothing.
        endcase
      end
    end
    pending_reads <= expected_reads.size();
  end

endmodule

// ===== dv/hough_line_accumulator_test.sv =====
`timescale 1ns / 1ps
// Drives the Hough line accumulator with vote, read, clear and spare-opcode items
// under a series of register settings. The checker beside the block predicts every
// read result and counts mismatches; this module only makes stimulus and decides
// the verdict.
module hough_line_accumulator_test;
  import hla_pkg::*;

  // The slowest correct run is dominated by the clearing sweep after reset and three
  // clears, plus some five hundred votes. The limit leaves a wide margin above that.
  localparam int         CYCLE_LIMIT = 3_000_000;
  // Pause after the block drops busy, so that the last vote has surely been written
  // back before the registers change.
  localparam int         SETTLE      = 16;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 116;
  localparam int         LINE_ITEMS  = 40;
  localparam real        PI_REAL     = 3.141592653589793;
  localparam logic [1:0] OP_SPARE    = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  hla_cmd_t    cmd_i = '0;
  logic        busy_o;
  logic        result_valid_o;
  hla_result_t result_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = REG_THRESHOLD;
  logic [15:0] cfg_wdata_i = '0;

  int          fail_count;
  int          reads_pending;
  int          cycle_count = 0;
  int          idle_pct = 30;

  // The stimulus keeps its own view of the geometry so that it can aim points at a
  // known line and then read the cells around that line's peak.
  real         origin_units = -10.0;
  real         bins_per_unit = 12.8;
  int          line_angle;
  int          line_bin;
  real         line_rho;

  hough_line_accumulator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  hough_line_accumulator_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .cmd_i           (cmd_i),
    .busy_i          (busy_o),
    .result_valid_i  (result_valid_o),
    .result_i        (result_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (fail_count),
    .reads_pending_o (reads_pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // A hung handshake or a read result that never comes ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every field random, so that the fields an opcode ignores still see both values
  // on every bit.
  function automatic hla_cmd_t random_item(logic [1:0] op);
    hla_cmd_t    item;
    logic [31:0] bits;
    bits = $urandom;
    item.point_x = bits[15:0];
    item.point_y = bits[31:16];
    bits = $urandom;
    item.angle_index = bits[7:0];
    item.distance_index = bits[15:8];
    item.opcode = op;
    return item;
  endfunction

  function automatic hla_cmd_t read_at(logic [7:0] a, logic [7:0] r);
    hla_cmd_t item;
    item = random_item(OP_READ);
    item.angle_index = a;
    item.distance_index = r;
    return item;
  endfunction

  // Rounds a distance in units to Q4.11 and clips it to the field's range.
  function automatic logic [15:0] to_q11(real v);
    int q;
    q = $rtoi(v * 2048.0 + (v < 0.0 ? -0.5 : 0.5));
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Chooses a line (angle step, rho) whose peak falls in a bin the current settings
  // can hold, preferring a rho that points inside the coordinate range can reach.
  function automatic void pick_line();
    line_angle = $urandom_range(DEF_ANGLE_STEPS - 1);
    for (int tries = 0; tries < 8; tries++) begin
      line_bin = $urandom_range(DEF_DISTANCE_BINS - 1);
      if (bins_per_unit > 0.0)
        line_rho = origin_units + (line_bin + 0.5) / bins_per_unit;
      else
        line_rho = origin_units + $urandom_range(4096) / 2048.0;
      if (line_rho <= 15.5 && line_rho >= -15.5) break;
    end
  endfunction

  // A point on the current line: the foot of the normal plus a random offset along
  // the line, kept short enough that the point stays inside Q4.11.
  function automatic hla_cmd_t line_vote();
    hla_cmd_t item;
    real      theta, span, s;
    item = random_item(OP_VOTE);
    theta = PI_REAL * line_angle / DEF_ANGLE_STEPS;
    span = 15.9 - (line_rho < 0.0 ? -line_rho : line_rho);
    if (span < 0.5) span = 0.5;
    s = ($urandom_range(65536) / 32768.0 - 1.0) * span;
    item.point_x = to_q11(line_rho * $cos(theta) - s * $sin(theta));
    item.point_y = to_q11(line_rho * $sin(theta) + s * $cos(theta));
    return item;
  endfunction

  // Reads the peak cell of the current line or one of its neighbors.
  function automatic hla_cmd_t line_read();
    int a, r;
    a = line_angle;
    if ($urandom_range(3) == 0) a = (line_angle + 1) % DEF_ANGLE_STEPS;
    r = line_bin + int'($urandom_range(2)) - 1;
    if (r < 0) r = 0;
    if (r > DEF_DISTANCE_BINS - 1) r = DEF_DISTANCE_BINS - 1;
    return read_at(a[7:0], r[7:0]);
  endfunction

  // Offers one item and returns at the edge that takes it. Idle cycles come first;
  // start stays high from one item to the next when none are drawn.
  task automatic issue(hla_cmd_t item);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= item;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Waits until the block is idle and every read result has come back.
  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (busy_o || reads_pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges; enable stays high throughout.
  task automatic set_config(logic [15:0] thr, logic [15:0] org, logic [15:0] scl);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_THRESHOLD;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_index_i <= REG_ORIGIN;
    cfg_wdata_i <= org;
    @(posedge clk_i);
    cfg_index_i <= REG_SCALE;
    cfg_wdata_i <= scl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    origin_units = $signed(org) / 2048.0;
    bins_per_unit = scl / 256.0;
  endtask

  initial begin : stimulus
    hla_cmd_t    item;
    int          roll;
    logic [31:0] bits;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers are taken during the clearing sweep that follows reset.
    set_config(THRESHOLD_RST, ORIGIN_RST, SCALE_RST);

    // Directed items. The origin lies at rho zero for every angle, which the reset
    // settings place in bin 128, so eleven votes there push a whole column of cells
    // past the threshold of ten.
    issue(read_at(8'd0, 8'd128));
    repeat (11) begin
      item = random_item(OP_VOTE);
      item.point_x = '0;
      item.point_y = '0;
      issue(item);
    end
    // Corner points: their rho falls below the origin or beyond the last bin for
    // most angles, so many of their votes are dropped.
    for (int k = 0; k < 4; k++) begin
      item = random_item(OP_VOTE);
      item.point_x = k[0] ? 16'h8000 : 16'h7FFF;
      item.point_y = k[1] ? 16'h8000 : 16'h7FFF;
      issue(item);
    end
    issue(read_at(8'd0, 8'd128));
    issue(read_at(8'd128, 8'd128));
    issue(read_at(8'd255, 8'd128));
    issue(read_at(8'd255, 8'd255));
    issue(random_item(OP_SPARE));
    issue(random_item(OP_CLEAR));
    issue(read_at(8'd0, 8'd128));
    issue(read_at(8'd255, 8'd0));

    // Random phases, each under its own settings. Most votes are points along a few
    // lines so that peaks build up; the rest are points anywhere in the field.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      idle_pct = 30;
      case (ph)
        0: set_config(16'd10, ORIGIN_RST, SCALE_RST);
        1: set_config(16'd0, 16'h8000, 16'hFFFF);
        2: set_config(16'hFFFF, 16'h7FFF, 16'h0000);
        3: set_config(16'd3, 16'h0000, 16'd1024);
        4: begin
          // A long stretch with the sender never idle.
          idle_pct = 0;
          set_config(16'd1, 16'hC000, 16'd6554);
        end
        5: begin
          bits = $urandom;
          set_config(16'($urandom_range(20)), bits[15:0], bits[31:16]);
        end
        6: set_config(16'd5, ORIGIN_RST, SCALE_RST);
        default: begin
          bits = $urandom;
          set_config(bits[15:0], bits[31:16], 16'($urandom_range(65535)));
        end
      endcase
      if (ph == 3 || ph == 6) issue(random_item(OP_CLEAR));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % LINE_ITEMS == 0) pick_line();
        roll = $urandom_range(99);
        if (roll < 45)
          item = line_vote();
        else if (roll < 55)
          item = random_item(OP_VOTE);
        else if (roll < 75)
          item = line_read();
        else if (roll < 97)
          item = random_item(OP_READ);
        else
          item = random_item(OP_SPARE);
        issue(item);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hla_pkg.sv
hdl/hla_trig_rom.sv
hdl/hla_rho_unit.sv
hdl/hla_vote_store.sv
hdl/hough_line_accumulator.sv
hdl/hla_checker.sv
dv/hough_line_accumulator_checker.sv
dv/hough_line_accumulator_test.sv
